@@ hw/rtl/kmp_stream_matcher_assert.svh @@
// Assertion macros used by the matcher's datapath.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef KMP_STREAM_MATCHER_ASSERT_SVH
`define KMP_STREAM_MATCHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define KMS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define KMS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/kms_pkg.sv @@
// Shared types, codes and the microprogram of the KMP stream matcher.
// Used by the sequencer, the datapath and the top level.
package kms_pkg;

  // Command codes carried by an input transfer.
  typedef enum logic [1:0] {
    CMD_PATTERN = 2'd0,
    CMD_TEXT    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Status codes carried by a result transfer.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    U_FETCH     = 4'd0,
    U_LOAD_CHK  = 4'd1,
    U_TEXT_CHK  = 4'd2,
    U_CLEAR     = 4'd3,
    U_RD_PAT    = 4'd4,
    U_CMP       = 4'd5,
    U_LOAD_DONE = 4'd6,
    U_TEXT_DONE = 4'd7,
    U_TEXT_FALL = 4'd8,
    U_EMIT      = 4'd9
  } upc_t;

  // Datapath actions selected by a control word.
  typedef enum logic [3:0] {
    ACT_NOP       = 4'd0,
    ACT_FETCH     = 4'd1,
    ACT_LOAD_INIT = 4'd2,
    ACT_TEXT_INIT = 4'd3,
    ACT_CLEAR     = 4'd4,
    ACT_RD_PAT    = 4'd5,
    ACT_CMP       = 4'd6,
    ACT_LOAD_DONE = 4'd7,
    ACT_TEXT_DONE = 4'd8,
    ACT_TEXT_FALL = 4'd9,
    ACT_EMIT      = 4'd10
  } act_t;

  // Branch conditions evaluated by the sequencer.
  typedef enum logic [2:0] {
    BR_GOTO      = 3'd0,
    BR_DISPATCH  = 3'd1,
    BR_LOAD      = 3'd2,
    BR_TEXT      = 3'd3,
    BR_CMP       = 3'd4,
    BR_FULLMATCH = 3'd5,
    BR_OUT_FREE  = 3'd6
  } br_t;

  // One control word of the microprogram.
  typedef struct packed {
    act_t act;
    br_t  br;
    upc_t target;
  } ctrl_word_t;

  // Condition flags reported by the datapath to the sequencer.
  typedef struct packed {
    logic accept;
    cmd_t cmd;
    logic full;
    logic len_zero;
    logic hit;
    logic j_zero;
    logic j_is_len;
    logic mode_text;
    logic out_free;
  } dp_flags_t;

  // Control store: one word per microprogram step.
  function automatic ctrl_word_t ucode(input upc_t pc);
    ctrl_word_t w;
    case (pc)
      U_FETCH:     w = '{act: ACT_FETCH,     br: BR_DISPATCH,  target: U_FETCH};
      U_LOAD_CHK:  w = '{act: ACT_LOAD_INIT, br: BR_LOAD,      target: U_RD_PAT};
      U_TEXT_CHK:  w = '{act: ACT_TEXT_INIT, br: BR_TEXT,      target: U_RD_PAT};
      U_CLEAR:     w = '{act: ACT_CLEAR,     br: BR_GOTO,      target: U_EMIT};
      U_RD_PAT:    w = '{act: ACT_RD_PAT,    br: BR_GOTO,      target: U_CMP};
      U_CMP:       w = '{act: ACT_CMP,       br: BR_CMP,       target: U_RD_PAT};
      U_LOAD_DONE: w = '{act: ACT_LOAD_DONE, br: BR_GOTO,      target: U_EMIT};
      U_TEXT_DONE: w = '{act: ACT_TEXT_DONE, br: BR_FULLMATCH, target: U_EMIT};
      U_TEXT_FALL: w = '{act: ACT_TEXT_FALL, br: BR_GOTO,      target: U_EMIT};
      U_EMIT:      w = '{act: ACT_EMIT,      br: BR_OUT_FREE,  target: U_FETCH};
      default:     w = '{act: ACT_NOP,       br: BR_GOTO,      target: U_FETCH};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/kms_in_if.sv @@
// Input channel of the matcher: valid/ready handshake with command and byte.
// Standalone; no package dependency.
interface kms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] byte_value;

  modport source (output valid, output command, output byte_value, input ready);
  modport sink (input valid, input command, input byte_value, output ready);
endinterface

@@ hw/rtl/kms_out_if.sv @@
// Result channel of the matcher: valid/ready handshake with match report.
// Standalone; no package dependency.
interface kms_out_if;
  logic        valid;
  logic        ready;
  logic        match_found;
  logic [31:0] match_start;
  logic [1:0]  status;

  modport source (output valid, output match_found, output match_start, output status,
                  input ready);
  modport sink (input valid, input match_found, input match_start, input status,
                output ready);
endinterface

@@ hw/rtl/kms_sequencer.sv @@
// Microprogram sequencer: step counter, control store lookup and branches.
// Depends on kms_pkg for the control word, flags and microprogram.
module kms_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  kms_pkg::dp_flags_t    flags,
  output kms_pkg::ctrl_word_t   ctrl
);

  kms_pkg::upc_t upc;
  kms_pkg::upc_t upc_next;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= kms_pkg::U_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

  // Control word lookup and branch resolution.
  always_comb begin
    ctrl = kms_pkg::ucode(upc);
    upc_next = ctrl.target;
    case (ctrl.br)
      kms_pkg::BR_GOTO: begin
        upc_next = ctrl.target;
      end
      kms_pkg::BR_DISPATCH: begin
        if (!flags.accept) begin
          upc_next = upc;
        end else begin
          case (flags.cmd)
            kms_pkg::CMD_PATTERN: upc_next = kms_pkg::U_LOAD_CHK;
            kms_pkg::CMD_TEXT:    upc_next = kms_pkg::U_TEXT_CHK;
            kms_pkg::CMD_CLEAR:   upc_next = kms_pkg::U_CLEAR;
            default:              upc_next = kms_pkg::U_EMIT;
          endcase
        end
      end
      kms_pkg::BR_LOAD: begin
        if (flags.full) begin
          upc_next = kms_pkg::U_EMIT;
        end else if (flags.len_zero) begin
          upc_next = kms_pkg::U_LOAD_DONE;
        end
      end
      kms_pkg::BR_TEXT: begin
        if (flags.len_zero) begin
          upc_next = kms_pkg::U_EMIT;
        end
      end
      kms_pkg::BR_CMP: begin
        // The failure walk ends on a hit or at the empty border.
        if (flags.hit || flags.j_zero) begin
          upc_next = flags.mode_text ? kms_pkg::U_TEXT_DONE : kms_pkg::U_LOAD_DONE;
        end
      end
      kms_pkg::BR_FULLMATCH: begin
        if (flags.j_is_len) begin
          upc_next = kms_pkg::U_TEXT_FALL;
        end
      end
      kms_pkg::BR_OUT_FREE: begin
        if (!flags.out_free) begin
          upc_next = upc;
        end
      end
      default: begin
        upc_next = kms_pkg::U_FETCH;
      end
    endcase
  end

endmodule

@@ hw/rtl/kms_datapath.sv @@
// Matcher datapath: pattern and failure memories, border registers, text
// position and the result register. Depends on kms_pkg and the assert macros.
`include "kmp_stream_matcher_assert.svh"

module kms_datapath #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  kms_pkg::ctrl_word_t  ctrl,
  output kms_pkg::dp_flags_t   flags,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [7:0]           byte_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 match_found,
  output logic [31:0]          match_start,
  output logic [1:0]           status
);

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  // Architectural state.
  logic [LEN_W-1:0]         len;
  logic [LEN_W-1:0]         load_border;
  logic [LEN_W-1:0]         match_border;
  logic [POSITION_BITS-1:0] pos;

  // Working registers of the current item.
  kms_pkg::cmd_t    cmd_r;
  logic [7:0]       b_r;
  logic [LEN_W-1:0] j;
  logic             found_r;
  logic [31:0]      start_r;
  kms_pkg::status_t status_r;

  // Memories and their registered read data.
  logic [7:0]        pat_mem  [MAX_PATTERN];
  logic [ADDR_W-1:0] fail_mem [MAX_PATTERN];
  logic [7:0]        pat_q;
  logic [ADDR_W-1:0] fail_q;
  logic [ADDR_W-1:0] fail_addr;

  // Result register.
  logic             out_valid_r;
  logic             out_found;
  logic [31:0]      out_start;
  kms_pkg::status_t out_status;

  logic             accept;
  logic             out_free;
  logic             load_out;
  logic [LEN_W-1:0] j_dec;
  logic [LEN_W-1:0] len_dec;
  logic [LEN_W-1:0] fail_ext;
  logic             full;
  logic             len_zero;
  logic             hit;

  // Handshake and condition decode. No transfer is taken while reset is high.
  always_comb begin
    in_ready = !rst && (ctrl.act == kms_pkg::ACT_FETCH);
    accept   = in_valid && in_ready;
    out_free = !out_valid_r || out_ready;
    load_out = (ctrl.act == kms_pkg::ACT_EMIT) && out_free;
    j_dec    = j - 1'b1;
    len_dec  = len - 1'b1;
    fail_ext = LEN_W'(fail_q);
    full     = (len == LEN_W'(MAX_PATTERN));
    len_zero = (len == '0);
    hit      = (pat_q == b_r);
    fail_addr = (ctrl.act == kms_pkg::ACT_TEXT_DONE) ? len_dec[ADDR_W-1:0]
                                                     : j_dec[ADDR_W-1:0];

    flags.accept    = accept;
    flags.cmd       = kms_pkg::cmd_t'(command);
    flags.full      = full;
    flags.len_zero  = len_zero;
    flags.hit       = hit;
    flags.j_zero    = (j == '0);
    flags.j_is_len  = (j == len);
    flags.mode_text = (cmd_r == kms_pkg::CMD_TEXT);
    flags.out_free  = out_free;
  end

  // Pattern byte memory: written on load, read at the current border.
  always_ff @(posedge clk) begin
    if (ctrl.act == kms_pkg::ACT_LOAD_DONE) begin
      pat_mem[len[ADDR_W-1:0]] <= b_r;
    end
    if (ctrl.act == kms_pkg::ACT_RD_PAT) begin
      pat_q <= pat_mem[j[ADDR_W-1:0]];
    end
  end

  // Failure memory: read at border minus one, or at the last pattern entry.
  always_ff @(posedge clk) begin
    if (ctrl.act == kms_pkg::ACT_LOAD_DONE) begin
      fail_mem[len[ADDR_W-1:0]] <= j[ADDR_W-1:0];
    end
    if ((ctrl.act == kms_pkg::ACT_RD_PAT) || (ctrl.act == kms_pkg::ACT_TEXT_DONE)) begin
      fail_q <= fail_mem[fail_addr];
    end
  end

  // Pattern length, borders and text position.
  always_ff @(posedge clk) begin
    if (rst) begin
      len          <= '0;
      load_border  <= '0;
      match_border <= '0;
      pos          <= '0;
    end else begin
      case (ctrl.act)
        kms_pkg::ACT_CLEAR: begin
          len          <= '0;
          load_border  <= '0;
          match_border <= '0;
          pos          <= '0;
        end
        kms_pkg::ACT_LOAD_DONE: begin
          load_border <= j;
          len         <= len + 1'b1;
        end
        kms_pkg::ACT_TEXT_DONE: begin
          match_border <= j;
          pos          <= pos + 1'b1;
        end
        kms_pkg::ACT_TEXT_FALL: begin
          match_border <= fail_ext;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    case (ctrl.act)
      kms_pkg::ACT_FETCH: begin
        if (accept) begin
          cmd_r    <= kms_pkg::cmd_t'(command);
          b_r      <= byte_value;
          found_r  <= 1'b0;
          start_r  <= '0;
          status_r <= kms_pkg::ST_OK;
        end
      end
      kms_pkg::ACT_LOAD_INIT: begin
        j <= len_zero ? '0 : load_border;
        if (full) begin
          status_r <= kms_pkg::ST_FULL;
        end
      end
      kms_pkg::ACT_TEXT_INIT: begin
        j <= match_border;
        if (len_zero) begin
          status_r <= kms_pkg::ST_EMPTY;
        end
      end
      kms_pkg::ACT_CMP: begin
        // Extend on a hit, otherwise follow the failure link.
        if (hit) begin
          j <= j + 1'b1;
        end else if (j != '0) begin
          j <= fail_ext;
        end
      end
      kms_pkg::ACT_TEXT_DONE: begin
        if (j == len) begin
          found_r <= 1'b1;
          start_r <= 32'(pos - POSITION_BITS'(len) + 1'b1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register parts the datapath from a stalled receiver.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found  <= found_r;
      out_start  <= start_r;
      out_status <= status_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign match_found = out_found;
  assign match_start = out_start;
  assign status      = out_status;

  // Design invariants.
  `KMS_ASSERT_NOW(a_read_below_len, ctrl.act == kms_pkg::ACT_RD_PAT, j < len)
  `KMS_ASSERT_NOW(a_match_border_range, ctrl.act == kms_pkg::ACT_FETCH,
                  (match_border < len) || (match_border == '0))
  `KMS_ASSERT_NOW(a_load_border_range, ctrl.act == kms_pkg::ACT_FETCH,
                  (load_border < len) || (load_border == '0))
  `KMS_ASSERT_NOW(a_found_is_ok, out_valid_r && out_found, out_status == kms_pkg::ST_OK)
  `KMS_ASSERT_NEXT(a_position_step, ctrl.act == kms_pkg::ACT_TEXT_DONE,
                   pos == $past(pos) + 1'b1)

endmodule

@@ hw/rtl/kmp_stream_matcher.sv @@
// KMP stream matcher, top level.
// Items arrive on the items channel (command, byte_value); one result per item
// leaves on the results channel (match_found, match_start, status).
// Command 0 appends a pattern byte, 1 streams a text byte, 2 clears the pattern
// and the text offset; any other code yields an all-zero result.
// A microcoded sequencer runs each item through a short program; every compare
// step of the failure walk is one memory read plus one compare.
// Steps from fetch to result load: a pattern byte runs fetch, load check,
// compare steps (none for the first byte), load done and emit; a text byte runs
// fetch, text check, compare steps, text done, a fall on a full match, and emit;
// clear, full store, empty pattern: fetch, clear or check, emit; other: fetch, emit.
// The failure walk is amortized to under two compare steps per text byte.
// One item is in work at a time; ready is high only in the fetch step.
// A result register holds the finished result, so the next item can be taken
// while the receiver stalls; the block waits only if a second result is ready.
// Reset empties the pattern, zeroes the text offset and drops any pending
// result; the stores need no clearing pass. No transfer is taken during reset.
// Depends on kms_pkg, kms_in_if, kms_out_if, kms_sequencer and kms_datapath.
module kmp_stream_matcher #(
  parameter int MAX_PATTERN   = 32,
  parameter int POSITION_BITS = 32
) (
  input logic       clk,
  input logic       rst,
  kms_in_if.sink    items,
  kms_out_if.source results
);

  kms_pkg::ctrl_word_t ctrl;
  kms_pkg::dp_flags_t  flags;

  // Program sequencer.
  kms_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Datapath with memories and result register.
  kms_datapath #(
    .MAX_PATTERN   (MAX_PATTERN),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .flags       (flags),
    .in_valid    (items.valid),
    .in_ready    (items.ready),
    .command     (items.command),
    .byte_value  (items.byte_value),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .match_found (results.match_found),
    .match_start (results.match_start),
    .status      (results.status)
  );

endmodule
